/* rtl/scope_trigger_capture_control_unit_defines.svh */
// Assertion macros for the scope trigger capture control unit.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef SCOPE_TRIGGER_CAPTURE_CONTROL_UNIT_DEFINES_SVH
`define SCOPE_TRIGGER_CAPTURE_CONTROL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define STCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define STCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define STCC_ASSERT(lbl, prop, msg)
`define STCC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/stcc_pkg.sv */
package stcc_pkg;

    // Default parameter values
    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int DEF_SAMPLE_BITS  = 16;

    // Fixed field widths
    localparam int SCALED_W   = 26;
    localparam int RATIO_W    = 10;
    localparam int LEVEL_W    = 16;
    localparam int FLEN_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [FLEN_W-1:0]  FLEN_RESET  = FLEN_W'(4096);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1);

    // Item codes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_EXT    = 2'd1;
    localparam logic [1:0] MODE_PAUSE  = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    // Trigger modes
    localparam logic [1:0] TRIG_FREE   = 2'd0;
    localparam logic [1:0] TRIG_AUTO   = 2'd1;
    localparam logic [1:0] TRIG_SINGLE = 2'd2;

    // Edge selection
    localparam logic [1:0] EDGE_RISE   = 2'd0;
    localparam logic [1:0] EDGE_FALL   = 2'd1;
    localparam logic [1:0] EDGE_EITHER = 2'd2;

    // Reported run state
    localparam logic [1:0] RUN_WAIT    = 2'd0;
    localparam logic [1:0] RUN_CAPTURE = 2'd1;
    localparam logic [1:0] RUN_PAUSED  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_SOURCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_EDGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_ONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_TWO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 3'd6;

    // Per-item status from the control unit
    typedef struct packed {
        logic [1:0] run_state;
        logic       write_valid;
        logic       edge_found;
        logic       frame_done;
        logic       entered_pause;
    } t_status;

endpackage

/* rtl/stcc_edge.sv */
module stcc_edge #(
    parameter int SAMPLE_BITS = stcc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_one,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_two,
    input  logic                                i_source,
    input  logic [1:0]                          i_edge_sel,
    input  logic signed [stcc_pkg::LEVEL_W-1:0] i_level,
    output logic                                o_hit
);

    localparam int CMP_W = (SAMPLE_BITS > stcc_pkg::LEVEL_W) ? SAMPLE_BITS : stcc_pkg::LEVEL_W;

    logic signed [SAMPLE_BITS-1:0] r_prev_one;
    logic signed [SAMPLE_BITS-1:0] r_prev_two;
    logic signed [CMP_W-1:0]       w_cur;
    logic signed [CMP_W-1:0]       w_prv;
    logic signed [CMP_W-1:0]       w_lvl;
    logic                          w_rise;
    logic                          w_fall;

    assign w_cur = i_source ? CMP_W'(i_sample_two) : CMP_W'(i_sample_one);
    assign w_prv = i_source ? CMP_W'(r_prev_two) : CMP_W'(r_prev_one);
    assign w_lvl = CMP_W'(i_level);

    // equality on either side counts as a crossing
    assign w_rise = (w_prv <= w_lvl) && (w_cur >= w_lvl);
    assign w_fall = (w_prv >= w_lvl) && (w_cur <= w_lvl);

    always_comb begin
        case (i_edge_sel)
            stcc_pkg::EDGE_RISE: o_hit = w_rise;
            stcc_pkg::EDGE_FALL: o_hit = w_fall;
            default:             o_hit = w_rise || w_fall;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_one <= '0;
            r_prev_two <= '0;
        end else if (i_load) begin
            r_prev_one <= i_sample_one;
            r_prev_two <= i_sample_two;
        end
    end

endmodule

/* rtl/stcc_scale.sv */
module stcc_scale #(
    parameter int SAMPLE_BITS = stcc_pkg::DEF_SAMPLE_BITS
) (
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [stcc_pkg::RATIO_W-1:0]         i_ratio,
    output logic signed [stcc_pkg::SCALED_W-1:0] o_scaled
);

    localparam int PROD_W = SAMPLE_BITS + stcc_pkg::RATIO_W + 1;
    localparam int EXT_W  = (PROD_W > stcc_pkg::SCALED_W + 1) ? PROD_W : stcc_pkg::SCALED_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(2 ** (stcc_pkg::SCALED_W - 1) - 1);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-(2 ** (stcc_pkg::SCALED_W - 1)));

    logic signed [EXT_W-1:0] w_sample;
    logic signed [EXT_W-1:0] w_ratio;
    logic signed [EXT_W-1:0] w_prod;

    assign w_sample = EXT_W'(i_sample);
    assign w_ratio  = EXT_W'(i_ratio);
    assign w_prod   = w_sample * w_ratio;

    // clip to the result range
    always_comb begin
        if (w_prod > SAT_MAX) begin
            o_scaled = SAT_MAX[stcc_pkg::SCALED_W-1:0];
        end else if (w_prod < SAT_MIN) begin
            o_scaled = SAT_MIN[stcc_pkg::SCALED_W-1:0];
        end else begin
            o_scaled = w_prod[stcc_pkg::SCALED_W-1:0];
        end
    end

endmodule

/* rtl/stcc_fsm.sv */
`include "scope_trigger_capture_control_unit_defines.svh"

module stcc_fsm #(
    parameter int BUFFER_DEPTH = stcc_pkg::DEF_BUFFER_DEPTH,
    localparam int ADDR_W      = $clog2(BUFFER_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic [1:0]                        i_mode,
    input  logic                              i_hit,
    input  logic [1:0]                        i_trig_mode,
    input  logic [stcc_pkg::FLEN_W-1:0]       i_frame_len,
    output stcc_pkg::t_status                 o_status,
    output logic [ADDR_W-1:0]                 o_addr
);

    localparam int LEN_W = (stcc_pkg::FLEN_W > ADDR_W + 1) ? stcc_pkg::FLEN_W : ADDR_W + 1;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_CAPTURE = 2'd1,
        ST_PAUSED  = 2'd2
    } t_run_state;

    t_run_state        r_state;
    t_run_state        n_state;
    t_run_state        w_mid_state;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic [LEN_W-1:0]  w_len_ext;
    logic [LEN_W-1:0]  w_eff_len;
    logic [LEN_W-1:0]  w_pos_inc;
    logic              w_wrap;

    // zero length acts as one, oversize clips to the buffer depth
    assign w_len_ext = LEN_W'(i_frame_len);
    assign w_eff_len = (w_len_ext == '0) ? LEN_W'(1)
                     : (w_len_ext > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH)
                     : w_len_ext;
    assign w_pos_inc = LEN_W'(r_pos) + LEN_W'(1);
    assign w_wrap    = !(w_pos_inc < w_eff_len);

    // a trigger arms capture before the same pair is stored
    assign w_mid_state = (i_hit && (r_state == ST_WAIT)) ? ST_CAPTURE : r_state;

    always_comb begin
        n_state                = r_state;
        n_pos                  = r_pos;
        o_addr                 = '0;
        o_status.write_valid   = 1'b0;
        o_status.edge_found    = 1'b0;
        o_status.frame_done    = 1'b0;
        o_status.entered_pause = 1'b0;
        case (i_mode)
            stcc_pkg::MODE_SAMPLE: begin
                o_status.edge_found = i_hit;
                n_state             = w_mid_state;
                if (w_mid_state == ST_CAPTURE) begin
                    o_status.write_valid = 1'b1;
                    o_addr               = r_pos;
                    if (!w_wrap) begin
                        n_pos = r_pos + ADDR_W'(1);
                    end else begin
                        n_pos               = '0;
                        o_status.frame_done = 1'b1;
                        case (i_trig_mode)
                            stcc_pkg::TRIG_AUTO: n_state = ST_WAIT;
                            stcc_pkg::TRIG_SINGLE: begin
                                n_state                = ST_PAUSED;
                                o_status.entered_pause = 1'b1;
                            end
                            default: n_state = ST_CAPTURE;
                        endcase
                    end
                end
            end
            stcc_pkg::MODE_EXT: begin
                o_status.edge_found = 1'b1;
                if (r_state == ST_WAIT) begin
                    n_state = ST_CAPTURE;
                end
            end
            stcc_pkg::MODE_PAUSE: begin
                if (r_state != ST_PAUSED) begin
                    n_state                = ST_PAUSED;
                    o_status.entered_pause = 1'b1;
                end
            end
            default: begin
                if (r_state == ST_PAUSED) begin
                    n_state = ((i_trig_mode == stcc_pkg::TRIG_AUTO)
                               || (i_trig_mode == stcc_pkg::TRIG_SINGLE)) ? ST_WAIT : ST_CAPTURE;
                end
            end
        endcase
        o_status.run_state = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CAPTURE;
            r_pos   <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    `STCC_ASSERT(a_pos_in_buffer, r_pos <= ADDR_W'(BUFFER_DEPTH - 1), "write position beyond buffer")
    `STCC_ASSERT(a_hold_when_stalled, !i_advance |=> $stable(r_pos), "position moved without an item")

endmodule

/* rtl/scope_trigger_capture_control_unit.sv */
// An item taken in passes the input register and then the result register before it shows at o_out_valid.
// Throughput: one item per cycle; the path runs input register, edge check or 16x10 multiply
// with clipping, output register. A stalled output holds the result and the input register.
// Reset (synchronous, active low): both stages empty, capturing at position zero, previous
// samples zero, registers at their reset values (ratios one, frame length 4096).
`include "scope_trigger_capture_control_unit_defines.svh"

module scope_trigger_capture_control_unit #(
    parameter int BUFFER_DEPTH = stcc_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = stcc_pkg::DEF_SAMPLE_BITS,
    localparam int ADDR_W      = $clog2(BUFFER_DEPTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // register write port
    input  logic                                 i_cfg_we,
    input  logic [stcc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [stcc_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // item channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_mode,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_one,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_two,

    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_run_state_now,
    output logic                                 o_write_valid,
    output logic [ADDR_W-1:0]                    o_write_address,
    output logic signed [stcc_pkg::SCALED_W-1:0] o_scaled_one,
    output logic signed [stcc_pkg::SCALED_W-1:0] o_scaled_two,
    output logic                                 o_edge_found,
    output logic                                 o_frame_done,
    output logic                                 o_entered_pause
);

    // configuration registers
    logic [1:0]                          r_trig_mode;
    logic                                r_trig_source;
    logic [1:0]                          r_trig_edge;
    logic signed [stcc_pkg::LEVEL_W-1:0] r_trig_level;
    logic [stcc_pkg::RATIO_W-1:0]        r_ratio_one;
    logic [stcc_pkg::RATIO_W-1:0]        r_ratio_two;
    logic [stcc_pkg::FLEN_W-1:0]         r_frame_len;

    // input stage
    logic                          r_in_valid;
    logic [1:0]                    r_in_mode;
    logic signed [SAMPLE_BITS-1:0] r_in_one;
    logic signed [SAMPLE_BITS-1:0] r_in_two;

    // result stage
    logic                                 r_out_valid;
    stcc_pkg::t_status                    r_out_status;
    logic [ADDR_W-1:0]                    r_out_addr;
    logic signed [stcc_pkg::SCALED_W-1:0] r_out_one;
    logic signed [stcc_pkg::SCALED_W-1:0] r_out_two;

    logic                                 w_advance;
    logic                                 w_hit;
    stcc_pkg::t_status                    w_status;
    logic [ADDR_W-1:0]                    w_addr;
    logic signed [stcc_pkg::SCALED_W-1:0] w_scaled_one;
    logic signed [stcc_pkg::SCALED_W-1:0] w_scaled_two;

    // Move the held item into the result stage when that stage is empty or being drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_mode   <= stcc_pkg::TRIG_FREE;
            r_trig_source <= 1'b0;
            r_trig_edge   <= stcc_pkg::EDGE_RISE;
            r_trig_level  <= '0;
            r_ratio_one   <= stcc_pkg::RATIO_RESET;
            r_ratio_two   <= stcc_pkg::RATIO_RESET;
            r_frame_len   <= stcc_pkg::FLEN_RESET;
        end else if (i_cfg_we) begin
            // drop writes to unknown indexes
            case (i_cfg_idx)
                stcc_pkg::REG_TRIG_MODE:   r_trig_mode   <= i_cfg_data[1:0];
                stcc_pkg::REG_TRIG_SOURCE: r_trig_source <= i_cfg_data[0];
                stcc_pkg::REG_TRIG_EDGE:   r_trig_edge   <= i_cfg_data[1:0];
                stcc_pkg::REG_TRIG_LEVEL:  r_trig_level  <= i_cfg_data[stcc_pkg::LEVEL_W-1:0];
                stcc_pkg::REG_RATIO_ONE:   r_ratio_one   <= i_cfg_data[stcc_pkg::RATIO_W-1:0];
                stcc_pkg::REG_RATIO_TWO:   r_ratio_two   <= i_cfg_data[stcc_pkg::RATIO_W-1:0];
                stcc_pkg::REG_FRAME_LEN:   r_frame_len   <= i_cfg_data[stcc_pkg::FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: take a transfer whenever the stage frees up this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_mode <= i_mode;
            r_in_one  <= i_sample_one;
            r_in_two  <= i_sample_two;
        end
    end

    // Crossing check on raw samples; previous pair advances on every sample item.
    stcc_edge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_edge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_advance && (r_in_mode == stcc_pkg::MODE_SAMPLE)),
        .i_sample_one (r_in_one),
        .i_sample_two (r_in_two),
        .i_source     (r_trig_source),
        .i_edge_sel   (r_trig_edge),
        .i_level      (r_trig_level),
        .o_hit        (w_hit)
    );

    stcc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale_one (
        .i_sample (r_in_one),
        .i_ratio  (r_ratio_one),
        .o_scaled (w_scaled_one)
    );

    stcc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale_two (
        .i_sample (r_in_two),
        .i_ratio  (r_ratio_two),
        .o_scaled (w_scaled_two)
    );

    // Run state and write position; they advance only when an item moves on.
    stcc_fsm #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_mode      (r_in_mode),
        .i_hit       (w_hit),
        .i_trig_mode (r_trig_mode),
        .i_frame_len (r_frame_len),
        .o_status    (w_status),
        .o_addr      (w_addr)
    );

    // Result stage: fill on advance, empty once the consumer takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Scaled values read zero when nothing is written.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= w_status;
            r_out_addr   <= w_addr;
            r_out_one    <= w_status.write_valid ? w_scaled_one : '0;
            r_out_two    <= w_status.write_valid ? w_scaled_two : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_run_state_now = r_out_status.run_state;
    assign o_write_valid   = r_out_status.write_valid;
    assign o_write_address = r_out_addr;
    assign o_scaled_one    = r_out_one;
    assign o_scaled_two    = r_out_two;
    assign o_edge_found    = r_out_status.edge_found;
    assign o_frame_done    = r_out_status.frame_done;
    assign o_entered_pause = r_out_status.entered_pause;

    `STCC_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `STCC_ASSERT(a_pause_state, o_out_valid && o_entered_pause |-> o_run_state_now == stcc_pkg::RUN_PAUSED, "pause flag without paused state")
    `STCC_ASSERT(a_done_needs_write, o_out_valid && o_frame_done |-> o_write_valid, "frame done without a write")
    `STCC_ASSERT(a_idle_payload_zero, o_out_valid && !o_write_valid |-> o_write_address == '0 && o_scaled_one == '0 && o_scaled_two == '0, "payload not zero without a write")

endmodule
